@@ src/plob_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// plob_pkg
// Shared widths, level record and cell control types for the order book.
// ----------------------------------------------------------------------------
package plob_pkg;

  localparam int PRICE_LEVELS = 64;
  localparam int PRICE_W      = 40;
  localparam int IQTY_W       = 14;
  localparam int LQTY_W       = 32;
  localparam int TRADES_W     = 48;
  localparam int VOLUME_W     = 64;

  typedef struct packed {
    logic               valid;
    logic [PRICE_W-1:0] price;
    logic [LQTY_W-1:0]  qty;
  } level_t;

  typedef struct packed {
    logic               add;
    logic               any_hit;
    logic               dec;
    logic               remove;
    logic [PRICE_W-1:0] price;
    logic [IQTY_W-1:0]  add_qty;
    logic [LQTY_W-1:0]  dec_qty;
  } cell_ctl_t;

endpackage
`default_nettype wire

@@ src/plob_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// plob_in_if / plob_out_if
// Valid/ready channels for orders and match results.
// ----------------------------------------------------------------------------
interface plob_in_if;
  logic                            valid;
  logic                            ready;
  logic                            side;
  logic [plob_pkg::PRICE_W-1:0]    price;
  logic [plob_pkg::IQTY_W-1:0]     quantity;
  logic                            order_valid;
  modport source (output valid, side, price, quantity, order_valid, input ready);
  modport sink   (input valid, side, price, quantity, order_valid, output ready);
endinterface

interface plob_out_if;
  logic                            valid;
  logic                            ready;
  logic                            matched;
  logic [plob_pkg::LQTY_W-1:0]     match_quantity;
  logic                            book_full;
  logic [plob_pkg::TRADES_W-1:0]   trade_total;
  logic [plob_pkg::VOLUME_W-1:0]   volume_total;
  modport source (output valid, matched, match_quantity, book_full, trade_total,
                  volume_total, input ready);
  modport sink   (input valid, matched, match_quantity, book_full, trade_total,
                  volume_total, output ready);
endinterface
`default_nettype wire

@@ src/plob_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// plob_cell
// One price level of a sorted book: merge, insert-shift, pop-shift and head decrement.
// ----------------------------------------------------------------------------
module plob_cell (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               is_ask,
  input  wire logic               is_head,
  input  wire plob_pkg::cell_ctl_t ctl,
  input  wire plob_pkg::level_t   left,
  input  wire logic               left_cond,
  input  wire plob_pkg::level_t   right,
  output plob_pkg::level_t        lvl,
  output logic                    cond,
  output logic                    hit
);

  plob_pkg::level_t           lvl_r, lvl_nxt;
  logic                       better;
  logic [plob_pkg::LQTY_W:0]  sum;

  assign better = is_ask ? (ctl.price < lvl_r.price) : (ctl.price > lvl_r.price);
  assign cond   = !lvl_r.valid || better;
  assign hit    = lvl_r.valid && (lvl_r.price == ctl.price);
  assign sum    = {1'b0, lvl_r.qty} + {{(plob_pkg::LQTY_W + 1 - plob_pkg::IQTY_W){1'b0}},
                                       ctl.add_qty};
  assign lvl    = lvl_r;

  always_comb begin
    lvl_nxt = lvl_r;
    if (ctl.add) begin
      if (ctl.any_hit) begin
        if (hit) begin
          lvl_nxt.qty = sum[plob_pkg::LQTY_W] ? {plob_pkg::LQTY_W{1'b1}}
                                               : sum[plob_pkg::LQTY_W-1:0];
        end
      end else if (cond && !left_cond) begin
        lvl_nxt.valid = 1'b1;
        lvl_nxt.price = ctl.price;
        lvl_nxt.qty   = {{(plob_pkg::LQTY_W - plob_pkg::IQTY_W){1'b0}}, ctl.add_qty};
      end else if (cond) begin
        lvl_nxt = left;
      end
    end else if (ctl.remove) begin
      lvl_nxt = right;
    end else if (ctl.dec && is_head) begin
      lvl_nxt.qty = lvl_r.qty - ctl.dec_qty;
    end
  end

  always_ff @(posedge clk) begin
    lvl_r <= lvl_nxt;
    if (!rst_n) begin
      lvl_r.valid <= 1'b0;
    end
  end

endmodule
`default_nettype wire

@@ src/plob_book.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// plob_book
// One side of the book: a chain of level cells kept sorted, best at the head.
// ----------------------------------------------------------------------------
module plob_book (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          is_ask,
  input  wire logic                          add_en,
  input  wire logic [plob_pkg::PRICE_W-1:0]  add_price,
  input  wire logic [plob_pkg::IQTY_W-1:0]   add_qty,
  input  wire logic                          match_en,
  input  wire logic [plob_pkg::LQTY_W-1:0]   fill_qty,
  output plob_pkg::level_t                   head,
  output logic                               dropped
);

  localparam int N = plob_pkg::PRICE_LEVELS;

  plob_pkg::level_t    lvls   [N];
  plob_pkg::level_t    lefts  [N];
  plob_pkg::level_t    rights [N];
  logic [N-1:0]        conds;
  logic [N-1:0]        hits;
  logic [N-1:0]        lconds;
  plob_pkg::cell_ctl_t ctl;
  plob_pkg::level_t    empty_lvl;

  assign empty_lvl = '{valid: 1'b0, price: add_price, qty: '0};
  assign head      = lvls[0];
  assign dropped   = add_en && lvls[N-1].valid && !(|hits);

  always_comb begin
    ctl.add     = add_en && !dropped;
    ctl.any_hit = |hits;
    ctl.dec     = match_en;
    ctl.remove  = match_en && (lvls[0].qty == fill_qty);
    ctl.price   = add_price;
    ctl.add_qty = add_qty;
    ctl.dec_qty = fill_qty;
  end

  for (genvar i = 0; i < N; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign lefts[i]  = empty_lvl;
      assign lconds[i] = 1'b0;
    end else begin : g_mid
      assign lefts[i]  = lvls[i-1];
      assign lconds[i] = conds[i-1];
    end
    if (i == N - 1) begin : g_last
      assign rights[i] = empty_lvl;
    end else begin : g_inner
      assign rights[i] = lvls[i+1];
    end
    plob_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .is_ask    (is_ask),
      .is_head   (i == 0),
      .ctl       (ctl),
      .left      (lefts[i]),
      .left_cond (lconds[i]),
      .right     (rights[i]),
      .lvl       (lvls[i]),
      .cond      (conds[i]),
      .hit       (hits[i])
    );
  end

endmodule
`default_nettype wire

@@ src/price_level_order_book_match_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// price_level_order_book_match_core
// Two sorted level chains; add an order, then match the best bid and ask.
// ----------------------------------------------------------------------------
// Flow: one word at a time. Add pass through the cell chain as the word is
// accepted in IDLE, then match pass on the chain heads in MATCH, which holds
// while the previous result word is unread; the result word is registered.
// Reset: rst_n synchronous, clears both books, totals and channel state.
module price_level_order_book_match_core (
  input  wire logic  clk,
  input  wire logic  rst_n,
  plob_in_if.sink    in_ch,
  plob_out_if.source out_ch
);

  typedef enum logic {S_IDLE, S_MATCH} state_t;

  state_t                          state_r;
  logic                            ovalid_r;
  logic                            full_r;
  logic                            out_valid_r;
  logic                            matched_r;
  logic [plob_pkg::LQTY_W-1:0]     mqty_r;
  logic                            out_full_r;
  logic [plob_pkg::TRADES_W-1:0]   trades_r;
  logic [plob_pkg::VOLUME_W-1:0]   volume_r;

  logic                            accept, go, crossed;
  logic                            bid_drop, ask_drop;
  logic [plob_pkg::LQTY_W-1:0]     mq;
  plob_pkg::level_t                bid_head, ask_head;

  assign in_ch.ready = (state_r == S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign go          = (state_r == S_MATCH) && (!out_valid_r || out_ch.ready);
  assign crossed     = ovalid_r && bid_head.valid && ask_head.valid &&
                       (bid_head.price >= ask_head.price);
  assign mq          = (bid_head.qty < ask_head.qty) ? bid_head.qty : ask_head.qty;

  plob_book u_bid (
    .clk       (clk),
    .rst_n     (rst_n),
    .is_ask    (1'b0),
    .add_en    (accept && in_ch.order_valid && !in_ch.side),
    .add_price (in_ch.price),
    .add_qty   (in_ch.quantity),
    .match_en  (go && crossed),
    .fill_qty  (mq),
    .head      (bid_head),
    .dropped   (bid_drop)
  );

  plob_book u_ask (
    .clk       (clk),
    .rst_n     (rst_n),
    .is_ask    (1'b1),
    .add_en    (accept && in_ch.order_valid && in_ch.side),
    .add_price (in_ch.price),
    .add_qty   (in_ch.quantity),
    .match_en  (go && crossed),
    .fill_qty  (mq),
    .head      (ask_head),
    .dropped   (ask_drop)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      trades_r    <= '0;
      volume_r    <= '0;
      ovalid_r    <= 1'b0;
      full_r      <= 1'b0;
    end else begin
      if (out_valid_r && out_ch.ready && !go) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            ovalid_r <= in_ch.order_valid;
            full_r   <= bid_drop || ask_drop;
            state_r  <= S_MATCH;
          end
        end
        S_MATCH: begin
          if (go) begin
            out_valid_r <= 1'b1;
            matched_r   <= crossed;
            mqty_r      <= crossed ? mq : '0;
            out_full_r  <= full_r;
            if (crossed) begin
              trades_r <= trades_r + plob_pkg::TRADES_W'(1);
              volume_r <= volume_r + {{(plob_pkg::VOLUME_W - plob_pkg::LQTY_W){1'b0}}, mq};
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.matched        = matched_r;
  assign out_ch.match_quantity = mqty_r;
  assign out_ch.book_full      = out_full_r;
  assign out_ch.trade_total    = trades_r;
  assign out_ch.volume_total   = volume_r;

endmodule
`default_nettype wire

@@ bench/plob_tb_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plob_tb_if
// Bench-side note: the channel interfaces come with the RTL in plob_if.sv.
// This file only holds the shared order and fill records used by the bench.
// ----------------------------------------------------------------------------
package plob_tb_pkg;
  import plob_pkg::*;

  typedef struct {
    logic               side;
    logic [PRICE_W-1:0] price;
    logic [IQTY_W-1:0]  quantity;
    logic               order_valid;
  } order_t;

  typedef struct {
    logic                matched;
    logic [LQTY_W-1:0]   match_quantity;
    logic                book_full;
    logic [TRADES_W-1:0] trade_total;
    logic [VOLUME_W-1:0] volume_total;
  } fill_t;
endpackage

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Bench for the order book matcher: drives orders over the input channel,
// predicts each fill report from its own book copy and checks every field.
// ----------------------------------------------------------------------------
import plob_pkg::*;
import plob_tb_pkg::*;

class book_scoreboard;
  logic [PRICE_W-1:0]  bid_px[PRICE_LEVELS];
  logic [LQTY_W-1:0]   bid_qt[PRICE_LEVELS];
  int                  bid_n;
  logic [PRICE_W-1:0]  ask_px[PRICE_LEVELS];
  logic [LQTY_W-1:0]   ask_qt[PRICE_LEVELS];
  int                  ask_n;
  logic [TRADES_W-1:0] trades;
  logic [VOLUME_W-1:0] volume;
  fill_t               pending[$];
  int                  errors;

  function new();
    bid_n = 0; ask_n = 0; trades = 0; volume = 0; errors = 0;
  endfunction

  function void note_order(order_t o);
    fill_t f;
    logic [32:0] s;
    int i, bb, ba;
    bit hit;
    logic [LQTY_W-1:0] m;
    f.matched = 0; f.match_quantity = 0; f.book_full = 0;
    if (o.order_valid) begin
      hit = 0;
      if (o.side == 0) begin
        for (i = 0; i < bid_n; i++)
          if (bid_px[i] == o.price) begin
            s = bid_qt[i] + o.quantity;
            bid_qt[i] = s[32] ? '1 : s[31:0];
            hit = 1;
          end
        if (!hit) begin
          if (bid_n >= PRICE_LEVELS) f.book_full = 1;
          else begin
            bid_px[bid_n] = o.price; bid_qt[bid_n] = LQTY_W'(o.quantity); bid_n++;
          end
        end
      end else begin
        for (i = 0; i < ask_n; i++)
          if (ask_px[i] == o.price) begin
            s = ask_qt[i] + o.quantity;
            ask_qt[i] = s[32] ? '1 : s[31:0];
            hit = 1;
          end
        if (!hit) begin
          if (ask_n >= PRICE_LEVELS) f.book_full = 1;
          else begin
            ask_px[ask_n] = o.price; ask_qt[ask_n] = LQTY_W'(o.quantity); ask_n++;
          end
        end
      end
      if (bid_n > 0 && ask_n > 0) begin
        bb = 0; ba = 0;
        for (i = 1; i < bid_n; i++) if (bid_px[i] > bid_px[bb]) bb = i;
        for (i = 1; i < ask_n; i++) if (ask_px[i] < ask_px[ba]) ba = i;
        if (bid_px[bb] >= ask_px[ba]) begin
          m = (bid_qt[bb] < ask_qt[ba]) ? bid_qt[bb] : ask_qt[ba];
          f.matched = 1; f.match_quantity = m;
          trades = trades + 1;
          volume = volume + m;
          bid_qt[bb] -= m; ask_qt[ba] -= m;
          if (bid_qt[bb] == 0) begin
            bid_px[bb] = bid_px[bid_n-1]; bid_qt[bb] = bid_qt[bid_n-1]; bid_n--;
          end
          if (ask_qt[ba] == 0) begin
            ask_px[ba] = ask_px[ask_n-1]; ask_qt[ba] = ask_qt[ask_n-1]; ask_n--;
          end
        end
      end
    end
    f.trade_total = trades;
    f.volume_total = volume;
    pending.insert(pending.size(), f);
  endfunction

  function void check_fill(fill_t a);
    fill_t e;
    if (pending.size() == 0) begin
      $error("unexpected result word");
      errors++;
      return;
    end
    e = pending.pop_front();
    if (a.matched !== e.matched) begin
      $error("matched exp %0h got %0h", e.matched, a.matched); errors++;
    end
    if (a.match_quantity !== e.match_quantity) begin
      $error("match_quantity exp %0h got %0h", e.match_quantity, a.match_quantity);
      errors++;
    end
    if (a.book_full !== e.book_full) begin
      $error("book_full exp %0h got %0h", e.book_full, a.book_full); errors++;
    end
    if (a.trade_total !== e.trade_total) begin
      $error("trade_total exp %0h got %0h", e.trade_total, a.trade_total);
      errors++;
    end
    if (a.volume_total !== e.volume_total) begin
      $error("volume_total exp %0h got %0h", e.volume_total, a.volume_total);
      errors++;
    end
  endfunction
endclass

module tb_top;
  logic clk;
  logic rst_n;
  plob_in_if  in_ch();
  plob_out_if out_ch();

  price_level_order_book_match_core u_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  book_scoreboard sb;
  int  send_idle_pct;
  int  recv_stall_pct;
  bit  hold_recv;
  int  quiet_cycles;
  localparam int WATCHDOG = 20000;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // receiver
  always @(posedge clk) begin
    if (!rst_n) out_ch.ready <= 0;
    else if (hold_recv) out_ch.ready <= 0;
    else out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    fill_t f;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        order_t o;
        o.side = in_ch.side; o.price = in_ch.price;
        o.quantity = in_ch.quantity; o.order_valid = in_ch.order_valid;
        sb.note_order(o);
      end
      if (out_ch.valid && out_ch.ready) begin
        f.matched = out_ch.matched; f.match_quantity = out_ch.match_quantity;
        f.book_full = out_ch.book_full; f.trade_total = out_ch.trade_total;
        f.volume_total = out_ch.volume_total;
        sb.check_fill(f);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (rst_n === 1'b1);
    wait (quiet_cycles >= WATCHDOG);
    $display("simulation failed");
    $finish;
  end

  task automatic send_order(input logic s, input logic [PRICE_W-1:0] p,
                            input logic [IQTY_W-1:0] q, input logic v);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 0;
      @(posedge clk);
    end
    in_ch.valid <= 1; in_ch.side <= s; in_ch.price <= p;
    in_ch.quantity <= q; in_ch.order_valid <= v;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic drain();
    in_ch.valid <= 0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic rand_order(input logic [PRICE_W-1:0] base, input int spread);
    logic [PRICE_W-1:0] p;
    logic [IQTY_W-1:0]  q;
    int r;
    r = $urandom_range(99);
    if (r < 4) p = PRICE_W'({$urandom, $urandom} % 64'd1000000000000);
    else p = base + $urandom_range(spread);
    q = ($urandom_range(9) == 0) ? IQTY_W'($urandom_range(16383))
                                 : IQTY_W'($urandom_range(10000));
    send_order(1'($urandom_range(1)), p, q, $urandom_range(9) != 0);
  endtask

  initial begin
    int i, ph;
    sb = new();
    in_ch.valid = 0; in_ch.side = 0; in_ch.price = 0;
    in_ch.quantity = 0; in_ch.order_valid = 0;
    send_idle_pct = 0; recv_stall_pct = 0; hold_recv = 0;
    rst_n = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // directed
    send_order(1'b0, 40'd100, 14'd10, 1'b0);
    send_order(1'b0, 40'd0, 14'd0, 1'b1);
    send_order(1'b1, 40'd0, 14'd5, 1'b1);
    send_order(1'b0, 40'hFF_FFFF_FFFF, 14'h3FFF, 1'b1);
    send_order(1'b1, 40'd999999999999, 14'd10000, 1'b1);
    send_order(1'b1, 40'd500, 14'd0, 1'b1);
    send_order(1'b0, 40'd500, 14'd7, 1'b1);
    send_order(1'b1, 40'd600, 14'd3, 1'b0);
    send_order(1'b0, 40'd10, 14'd1, 1'b1);
    send_order(1'b1, 40'd20, 14'd1, 1'b1);
    send_order(1'b0, 40'd20, 14'd1, 1'b1);
    drain();
    // fill the bid book past capacity, then add asks above it
    for (i = 0; i < PRICE_LEVELS + 3; i++) send_order(1'b0, 40'd1000 + i, 14'h3FFF, 1'b1);
    for (i = 0; i < 8; i++) send_order(1'b1, 40'd2000 + i, 14'd1, 1'b1);
    drain();
    // merge repeated orders into one ask level
    for (i = 0; i < 6; i++) send_order(1'b1, 40'd5000000, 14'h3FFF, 1'b1);
    drain();
    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 56; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 56; end
        default: begin send_idle_pct = 32; recv_stall_pct = 32; end
      endcase
      for (i = 0; i < 320; i++) rand_order(40'd100000 + ph * 1000, 60);
      drain();
    end
    // long receiver hold-off while orders keep coming
    fork
      begin
        hold_recv = 1;
        repeat (300) @(posedge clk);
        hold_recv = 0;
      end
      for (i = 0; i < 20; i++) rand_order(40'd7000, 10);
    join
    drain();
    if (sb.errors == 0 && sb.pending.size() == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end
endmodule

@@ filelist.f @@
src/plob_pkg.sv
src/plob_if.sv
src/plob_cell.sv
src/plob_book.sv
src/price_level_order_book_match_core.sv
bench/plob_tb_if.sv
bench/tb_top.sv
